[rtl/byte_mixing_hash_256_top_assert.svh]
// Assertion macros for the byte mixing hash block.
// Each macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef BYTE_MIXING_HASH_256_TOP_ASSERT_SVH
`define BYTE_MIXING_HASH_256_TOP_ASSERT_SVH

// Condition that must hold in the same cycle.
`define BMH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define BMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bmh_pkg.sv]
package bmh_pkg;

    localparam int unsigned HASH_BYTES = 32;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned DIGEST_W   = HASH_BYTES * BYTE_W;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word_0;
        logic [63:0] digest_word_1;
        logic [63:0] digest_word_2;
        logic [63:0] digest_word_3;
    } t_out_item;

    typedef enum logic [1:0] {
        ALU_ADD3,
        ALU_XOR,
        ALU_ADD,
        ALU_ROT
    } t_alu_op;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              clear;
    } t_store_ctl;

    // Initial state bytes: the SHA-256 initial words, big-endian.
    function automatic logic [7:0] init_byte(input logic [ADDR_W-1:0] addr);
        logic [7:0] v;
        case (addr)
            5'd0:  v = 8'h6a;
            5'd1:  v = 8'h09;
            5'd2:  v = 8'he6;
            5'd3:  v = 8'h67;
            5'd4:  v = 8'hbb;
            5'd5:  v = 8'h67;
            5'd6:  v = 8'hae;
            5'd7:  v = 8'h85;
            5'd8:  v = 8'h3c;
            5'd9:  v = 8'h6e;
            5'd10: v = 8'hf3;
            5'd11: v = 8'h72;
            5'd12: v = 8'ha5;
            5'd13: v = 8'h4f;
            5'd14: v = 8'hf5;
            5'd15: v = 8'h3a;
            5'd16: v = 8'h51;
            5'd17: v = 8'h0e;
            5'd18: v = 8'h52;
            5'd19: v = 8'h7f;
            5'd20: v = 8'h9b;
            5'd21: v = 8'h05;
            5'd22: v = 8'h68;
            5'd23: v = 8'h8c;
            5'd24: v = 8'h1f;
            5'd25: v = 8'h83;
            5'd26: v = 8'hd9;
            5'd27: v = 8'hab;
            5'd28: v = 8'h5b;
            5'd29: v = 8'he0;
            5'd30: v = 8'hcd;
            5'd31: v = 8'h19;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[rtl/byte_mixing_hash_256_top.sv]
// Absorb item: S_AB_MIX, S_AB_XOR and S_AB_ADD run from acceptance until the next item can be taken.
// Finish item: 128 mixing steps, each a read state and a write state, on the shared byte
// unit and the 2-read/1-write state memory, then the count is added byte by byte and the
// output is loaded before the result appears and the next item can be taken;
// a result still held by the consumer holds the finish back further.
// Reset (synchronous, active low) returns the state to the initial bytes and
// zeroes the byte count; the block also does so by itself after each finish.
`include "byte_mixing_hash_256_top_assert.svh"

module byte_mixing_hash_256_top
    import bmh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AB_MIX,
        S_AB_XOR,
        S_AB_ADD,
        S_FN_RD,
        S_FN_WR,
        S_DUMP,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [7:0]           r_count, n_count;
    logic [7:0]           r_byte, n_byte;
    logic [7:0]           r_acc, n_acc;
    logic [1:0]           r_round, n_round;
    logic [ADDR_W-1:0]    r_idx, n_idx;
    logic [ADDR_W:0]      r_dump, n_dump;
    logic [DIGEST_W-1:0]  r_dig, n_dig;
    t_out_item            r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    t_store_ctl           w_ctl;
    logic [7:0]           w_rd_a;
    logic [7:0]           w_rd_b;
    t_alu_op              w_op;
    logic [7:0]           w_alu_a;
    logic [7:0]           w_alu_b;
    logic [7:0]           w_alu_c;
    logic [7:0]           w_alu_y;
    logic [2:0]           w_rot;
    logic [ADDR_W-1:0]    w_pos;
    logic [ADDR_W-1:0]    w_partner;
    logic                 w_in_acc;
    logic                 w_out_free;

    // Absorb position and the finish-round partner of the current byte.
    assign w_pos      = r_count[ADDR_W-1:0];
    assign w_partner  = r_idx + 5'd13 + 5'(7 * r_round);
    assign w_rot      = 3'(r_round) + 3'd3;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    bmh_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_rd_a  (w_rd_a),
        .o_rd_b  (w_rd_b)
    );

    bmh_alu u_alu (
        .i_op  (w_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_c   (w_alu_c),
        .i_rot (w_rot),
        .o_y   (w_alu_y)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_byte      = r_byte;
        n_acc       = r_acc;
        n_round     = r_round;
        n_idx       = r_idx;
        n_dump      = r_dump;
        n_dig       = r_dig;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        w_ctl       = '0;
        w_op        = ALU_ADD;
        w_alu_a     = w_rd_a;
        w_alu_b     = w_rd_b;
        w_alu_c     = r_byte;

        // Drop the result once the consumer takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.mode) begin
                        n_round = '0;
                        n_idx   = '0;
                        n_state = S_FN_RD;
                    end else begin
                        // Fetch h[s] and h[s+3].
                        n_byte          = i_in_data.data_byte;
                        w_ctl.rd_en     = 1'b1;
                        w_ctl.rd_addr_a = w_pos;
                        w_ctl.rd_addr_b = w_pos + 5'd3;
                        n_state         = S_AB_MIX;
                    end
                end
            end
            S_AB_MIX: begin
                // Sum h[s] + byte + h[s+3]; fetch h[s+17] and h[s+7].
                w_op            = ALU_ADD3;
                n_acc           = w_alu_y;
                w_ctl.rd_en     = 1'b1;
                w_ctl.rd_addr_a = w_pos + 5'd17;
                w_ctl.rd_addr_b = w_pos + 5'd7;
                n_state         = S_AB_XOR;
            end
            S_AB_XOR: begin
                w_op          = ALU_XOR;
                w_alu_a       = r_acc;
                w_alu_b       = w_rd_a;
                n_acc         = w_alu_y;
                w_ctl.wr_en   = 1'b1;
                w_ctl.wr_addr = w_pos;
                w_ctl.wr_data = w_alu_y;
                n_state       = S_AB_ADD;
            end
            S_AB_ADD: begin
                // Fold the new h[s] into h[s+7] and advance the count.
                w_op          = ALU_ADD;
                w_alu_a       = w_rd_b;
                w_alu_b       = r_acc;
                w_ctl.wr_en   = 1'b1;
                w_ctl.wr_addr = w_pos + 5'd7;
                w_ctl.wr_data = w_alu_y;
                n_count       = r_count + 8'd1;
                n_state       = S_IDLE;
            end
            S_FN_RD: begin
                w_ctl.rd_en     = 1'b1;
                w_ctl.rd_addr_a = r_idx;
                w_ctl.rd_addr_b = w_partner;
                n_state         = S_FN_WR;
            end
            S_FN_WR: begin
                w_op          = ALU_ROT;
                w_ctl.wr_en   = 1'b1;
                w_ctl.wr_addr = r_idx;
                w_ctl.wr_data = w_alu_y;
                n_idx         = r_idx + 5'd1;
                if (r_idx == 5'd31) begin
                    n_round = r_round + 2'd1;
                end
                if (r_idx == 5'd31 && r_round == 2'd3) begin
                    n_dump  = '0;
                    n_state = S_DUMP;
                end else begin
                    n_state = S_FN_RD;
                end
            end
            S_DUMP: begin
                // Read one byte a cycle; shift in the previous one plus the count.
                w_op    = ALU_ADD;
                w_alu_a = w_rd_a;
                w_alu_b = r_count;
                if (r_dump != 6'(HASH_BYTES)) begin
                    w_ctl.rd_en     = 1'b1;
                    w_ctl.rd_addr_a = r_dump[ADDR_W-1:0];
                end
                if (r_dump != '0) begin
                    n_dig = {r_dig[DIGEST_W-BYTE_W-1:0], w_alu_y};
                end
                n_dump = r_dump + 6'd1;
                if (r_dump == 6'(HASH_BYTES)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free, then restart the state.
                if (w_out_free) begin
                    n_out.digest_word_0 = r_dig[255:192];
                    n_out.digest_word_1 = r_dig[191:128];
                    n_out.digest_word_2 = r_dig[127:64];
                    n_out.digest_word_3 = r_dig[63:0];
                    n_out_valid         = 1'b1;
                    w_ctl.clear         = 1'b1;
                    n_count             = '0;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_acc  <= n_acc;
        r_dig  <= n_dig;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_dump      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_round     <= n_round;
            r_idx       <= n_idx;
            r_dump      <= n_dump;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BMH_ASSERT_NEXT(a_finish_starts_mix, w_in_acc && i_in_data.mode, r_state == S_FN_RD, "finish item did not start the mixing rounds")
    `BMH_ASSERT_NOW(a_result_from_done, $rose(r_out_valid), $past(r_state) == S_DONE, "result raised outside the completion step")
    `BMH_ASSERT_NOW(a_partner_distinct, r_state == S_FN_RD, w_partner != r_idx, "mixing partner equals the updated byte")
    `BMH_ASSERT_NOW(a_count_change, r_count != $past(r_count), $past(r_state) == S_AB_ADD || $past(r_state) == S_DONE, "byte count changed outside absorb or finish")

endmodule

[rtl/bmh_alu.sv]
module bmh_alu
    import bmh_pkg::*;
(
    input  t_alu_op     i_op,
    input  logic [7:0]  i_a,
    input  logic [7:0]  i_b,
    input  logic [7:0]  i_c,
    input  logic [2:0]  i_rot,
    output logic [7:0]  o_y
);

    logic [8:0] w_sum9;
    logic [8:0] w_hi;
    logic [8:0] w_lo;

    // Low byte of the 9-bit sum rotated left by i_rot; the carry is ORed into bit i_rot.
    assign w_sum9 = {1'b0, i_a} + {1'b0, i_b};
    assign w_hi   = w_sum9 << i_rot;
    assign w_lo   = w_sum9 >> (4'd8 - {1'b0, i_rot});

    always_comb begin
        case (i_op)
            ALU_ADD3: o_y = 8'(i_a + i_b + i_c);
            ALU_XOR:  o_y = i_a ^ i_b;
            ALU_ADD:  o_y = 8'(i_a + i_b);
            ALU_ROT:  o_y = w_hi[7:0] | w_lo[7:0];
            default:  o_y = 8'(i_a + i_b);
        endcase
    end

endmodule

[rtl/bmh_store.sv]
module bmh_store
    import bmh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_store_ctl  i_ctl,
    output logic [7:0]  o_rd_a,
    output logic [7:0]  o_rd_b
);

    logic [BYTE_W-1:0]     r_mem [HASH_BYTES];
    logic [HASH_BYTES-1:0] r_valid;
    logic [BYTE_W-1:0]     r_rd_a;
    logic [BYTE_W-1:0]     r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
    end

    // An entry not yet written reads as its initial byte.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_a <= r_valid[i_ctl.rd_addr_a] ? r_mem[i_ctl.rd_addr_a]
                                               : init_byte(i_ctl.rd_addr_a);
            r_rd_b <= r_valid[i_ctl.rd_addr_b] ? r_mem[i_ctl.rd_addr_b]
                                               : init_byte(i_ctl.rd_addr_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_ctl.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

[tb/tb_byte_mixing_hash_256_top.sv]
module tb_byte_mixing_hash_256_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmh_pkg::*;

    // Item kinds carried in the mode field.
    localparam logic MODE_ABSORB = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // Starting state: the SHA-256 initial words, byte 0 in the top bits.
    localparam logic [255:0] IV_BYTES =
        256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;

    // Stimulus budget and the tail that follows the last digest.
    localparam int unsigned ITEM_BUDGET = 1100;
    localparam int unsigned MIN_DIGESTS = 48;
    localparam int unsigned TAIL_CYCLES = 300;

    // One pending item, with the idle profile it belongs to and an optional
    // hold-off until every outstanding digest has come back.
    typedef struct {
        t_in_item    item;
        int unsigned phase;
        bit          wait_empty;
    } t_feed_entry;

    // Idle percentages per phase: sender-heavy receiver stall first, then the
    // reverse, then a stretch with no idling at all.
    int unsigned tx_idle_pct [3] = '{16, 65, 0};
    int unsigned rx_idle_pct [3] = '{65, 16, 0};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // Predicted hash state: 32 mixing bytes and the message length mod 256.
    logic [7:0]  mix_state [32];
    logic [7:0]  msg_len;

    t_feed_entry feed_q [$];
    t_out_item   digest_q [$];

    int unsigned cur_phase   = 0;
    int unsigned n_queued    = 0;
    int unsigned n_accepted  = 0;
    int unsigned n_msgs      = 0;
    int unsigned n_absorbed  = 0;
    int unsigned longest_msg = 0;
    int unsigned n_checked   = 0;
    int unsigned n_errors    = 0;

    byte_mixing_hash_256_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Return the predicted state to the start of a message.
    function automatic void clear_hash_state();
        for (int i = 0; i < 32; i++) begin
            mix_state[i] = IV_BYTES[255 - 8*i -: 8];
        end
        msg_len = 8'd0;
    endfunction

    // Absorb one message byte at position len mod 32 and bump the length.
    function automatic void absorb_byte(input logic [7:0] b);
        logic [4:0] s;
        logic [7:0] v;
        s = msg_len[4:0];
        v = mix_state[s] + b + mix_state[5'(s + 3)];
        v = v ^ mix_state[5'(s + 17)];
        mix_state[s] = v;
        mix_state[5'(s + 7)] = mix_state[5'(s + 7)] + v;
        msg_len = msg_len + 8'd1;
    endfunction

    // Run the four rotate-mixing rounds, add the length, pack the digest and
    // start the next message from the initial state.
    function automatic t_out_item close_message();
        int unsigned    k;
        int unsigned    j;
        int unsigned    sum;
        logic [255:0]   flat;
        for (int r = 0; r < 4; r++) begin
            k = r + 3;
            for (int i = 0; i < 32; i++) begin
                j   = (i + 13 + 7*r) % 32;
                sum = mix_state[i] + mix_state[j];
                mix_state[i] = 8'(((sum << k) | (sum >> (8 - k))) & 32'hff);
            end
        end
        for (int i = 0; i < 32; i++) begin
            flat[255 - 8*i -: 8] = mix_state[i] + msg_len;
        end
        clear_hash_state();
        return t_out_item'(flat);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns mismatch: %s got %h want %h", $time, what, got, want);
        n_errors++;
    endtask

    task automatic push_item(input logic mode, input logic [7:0] b,
                             input int unsigned phase, input bit wait_empty);
        t_feed_entry e;
        e.item.mode      = mode;
        e.item.data_byte = b;
        e.phase          = phase;
        e.wait_empty     = wait_empty;
        feed_q.push_back(e);
        n_queued++;
    endtask

    // Queue a message of random bytes followed by its finish item; the finish
    // carries a random byte that the block must ignore.
    task automatic queue_message(input int unsigned len, input int unsigned phase,
                                 input bit wait_empty);
        for (int unsigned n = 0; n < len; n++) begin
            push_item(MODE_ABSORB, 8'($urandom_range(255, 0)), phase,
                      wait_empty && n == 0);
        end
        push_item(MODE_FINISH, 8'($urandom_range(255, 0)), phase,
                  wait_empty && len == 0);
        n_msgs++;
        n_absorbed += len;
        if (len > longest_msg) begin
            longest_msg = len;
        end
    endtask

    // Driver: predict on every accepted item, then present the next one or
    // idle. A presented item holds until it is taken.
    always @(posedge i_clk) begin : feed_driver
        t_feed_entry nxt;
        bit          hold;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                n_accepted++;
                if (i_in_data.mode == MODE_FINISH) begin
                    digest_q.push_back(close_message());
                end else begin
                    absorb_byte(i_in_data.data_byte);
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                hold = 1'b1;
                if (feed_q.size() != 0) begin
                    nxt  = feed_q[0];
                    // A flagged item waits until the block has drained.
                    hold = (nxt.wait_empty && digest_q.size() != 0) ||
                           ($urandom_range(99, 0) < tx_idle_pct[nxt.phase]);
                end
                if (hold) begin
                    i_in_valid <= 1'b0;
                end else begin
                    void'(feed_q.pop_front());
                    cur_phase  = nxt.phase;
                    i_in_valid <= 1'b1;
                    i_in_data  <= nxt.item;
                end
            end
        end
    end

    // Monitor: check each accepted digest against the oldest prediction, word
    // by word, and stall at random according to the current phase.
    always @(posedge i_clk) begin : digest_monitor
        logic [255:0] got_flat;
        logic [255:0] want_flat;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got_flat = o_out_data;
                if (digest_q.size() == 0) begin
                    report_mismatch("digest with none expected, word 0",
                                    got_flat[255 -: 64], 64'h0);
                end else begin
                    want_flat = digest_q.pop_front();
                    n_checked++;
                    for (int w = 0; w < 4; w++) begin
                        if (got_flat[255 - 64*w -: 64] !== want_flat[255 - 64*w -: 64]) begin
                            report_mismatch($sformatf("digest %0d word %0d", n_checked, w),
                                            got_flat[255 - 64*w -: 64],
                                            want_flat[255 - 64*w -: 64]);
                        end
                    end
                end
            end
            i_out_stall <= ($urandom_range(99, 0) < rx_idle_pct[cur_phase]);
        end
    end

    initial begin : stimulus
        int unsigned len;
        int unsigned phase;

        clear_hash_state();

        // Directed: empty message with a set data byte on the finish, single
        // extreme bytes, a short mixed message, then an empty message right
        // after a drain.
        push_item(MODE_FINISH, 8'hff, 0, 1'b0);
        push_item(MODE_ABSORB, 8'h00, 0, 1'b0);
        push_item(MODE_FINISH, 8'h00, 0, 1'b0);
        push_item(MODE_ABSORB, 8'hff, 0, 1'b0);
        push_item(MODE_FINISH, 8'hff, 0, 1'b0);
        push_item(MODE_ABSORB, 8'hff, 0, 1'b1);
        push_item(MODE_ABSORB, 8'h80, 0, 1'b0);
        push_item(MODE_ABSORB, 8'h01, 0, 1'b0);
        push_item(MODE_ABSORB, 8'h7f, 0, 1'b0);
        push_item(MODE_ABSORB, 8'h00, 0, 1'b0);
        push_item(MODE_FINISH, 8'h5a, 0, 1'b0);
        push_item(MODE_FINISH, 8'ha5, 0, 1'b1);
        n_msgs += 5;
        n_absorbed += 7;
        longest_msg = 5;

        // Length wrap: 256 bytes brings the count back to zero, 257 to one;
        // 33 bytes walks the position once round the state.
        queue_message(256, 0, 1'b0);
        queue_message(257, 0, 1'b1);
        queue_message(33, 0, 1'b0);

        // Random messages, mostly short, some spanning more than one lap.
        while (n_queued < ITEM_BUDGET || n_msgs < MIN_DIGESTS) begin
            phase = (n_queued * 3) / ITEM_BUDGET;
            if (phase > 2) begin
                phase = 2;
            end
            if ($urandom_range(7, 0) == 0) begin
                len = $urandom_range(40, 17);
            end else begin
                len = $urandom_range(16, 0);
            end
            queue_message(len, phase, $urandom_range(5, 0) == 0);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every item taken and every digest back, then a quiet tail
        // to catch anything extra.
        while (n_accepted < n_queued || digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (digest_q.size() != 0) begin
            report_mismatch($sformatf("%0d digests never arrived", digest_q.size()),
                            64'h0, 64'h0);
        end

        $display("run covered %0d messages, %0d bytes absorbed, longest %0d bytes",
                 n_msgs, n_absorbed, longest_msg);
        $display("digests compared: %0d, mismatches: %0d", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #20_000_000;
        $display("timeout after %0t ns", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[byte_mixing_hash_256_top.f]
+incdir+rtl
rtl/bmh_pkg.sv
rtl/bmh_alu.sv
rtl/bmh_store.sv
rtl/byte_mixing_hash_256_top.sv
tb/tb_byte_mixing_hash_256_top.sv
